// ===== hdl/ast_pkg.sv =====
package ast_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths
    localparam int KIND_BITS      = 2;
    localparam int ITEM_BITS      = 32;
    localparam int COUNT_OUT_BITS = 7;
    localparam int RES_DATA_BITS  = 16;

    // Operation codes (the unused code behaves as a check)
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CHECK  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_DECIDE,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } t_state;

    // Result of one request
    typedef struct packed {
        logic                      was_present;
        logic                      dropped_full;
        logic [COUNT_OUT_BITS-1:0] member_count;
    } t_result;

endpackage

// ===== hdl/ast_store.sv =====
module ast_store #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [VALUE_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]      i_raddr,
    output logic [VALUE_BITS-1:0] o_rdata
);

    // Entry array, no reset: only entries below the fill count are read
    logic [VALUE_BITS-1:0] r_mem [CAPACITY];
    logic [VALUE_BITS-1:0] r_rdata;

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ast_ctrl.sv =====
module ast_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [ast_pkg::KIND_BITS-1:0] i_kind,
    input  logic [ast_pkg::ITEM_BITS-1:0] i_item_value,
    // result side
    output logic                          o_done,
    input  logic                          i_take,
    output ast_pkg::t_result              o_result,
    // entry memory
    output logic                          o_mem_we,
    output logic [IDX_W-1:0]              o_mem_waddr,
    output logic [VALUE_BITS-1:0]         o_mem_wdata,
    output logic [IDX_W-1:0]              o_mem_raddr,
    input  logic [VALUE_BITS-1:0]         i_mem_rdata
);
    import ast_pkg::*;

    localparam int CMP_W = CNT_W + 1;
    localparam int EXT_W = ITEM_BITS + VALUE_BITS;

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_used, n_used;
    logic [KIND_BITS-1:0]  r_kind, n_kind;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_found, n_found;
    logic                  r_dropped, n_dropped;

    logic                  accept;
    logic                  match;
    logic [EXT_W-1:0]      item_ext;
    logic [CMP_W-1:0]      used_w, idx_p1, idx_p2;
    logic [IDX_W-1:0]      idx_inc;
    logic                  has_room;
    logic                  do_insert, do_remove;
    logic [CNT_W+COUNT_OUT_BITS-1:0] count_ext;

    // Value masked to the stored width
    assign item_ext = {{VALUE_BITS{1'b0}}, i_item_value};
    assign accept   = i_req_valid && o_req_ready;

    // Shared compare unit and index arithmetic
    assign match    = (i_mem_rdata == r_value);
    assign used_w   = CMP_W'(r_used);
    assign idx_p1   = CMP_W'(r_idx) + CMP_W'(1);
    assign idx_p2   = CMP_W'(r_idx) + CMP_W'(2);
    assign idx_inc  = IDX_W'(idx_p1);
    assign has_room = used_w < CMP_W'(CAPACITY);

    assign do_insert = (r_kind == KIND_INSERT) && !r_found;
    assign do_remove = (r_kind == KIND_REMOVE) && r_found;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (r_used == '0) ? ST_DECIDE : ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (match || idx_p1 == used_w) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_DECIDE: begin
                if (do_remove && idx_p1 < used_w) begin
                    n_state = ST_SH_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SH_RD: begin
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                n_state = (idx_p2 < used_w) ? ST_SH_RD : ST_DONE;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_idx     = r_idx;
        n_used    = r_used;
        n_kind    = r_kind;
        n_value   = r_value;
        n_found   = r_found;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind    = i_kind;
                    n_value   = item_ext[VALUE_BITS-1:0];
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_dropped = 1'b0;
                end
            end
            ST_CMP: begin
                if (match) begin
                    n_found = 1'b1;
                end else if (idx_p1 != used_w) begin
                    n_idx = idx_inc;
                end
            end
            ST_DECIDE: begin
                if (do_insert) begin
                    if (has_room) begin
                        n_used = r_used + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                end else if (do_remove && !(idx_p1 < used_w)) begin
                    n_used = r_used - CNT_W'(1);
                end
            end
            ST_SH_WR: begin
                n_idx = idx_inc;
                if (!(idx_p2 < used_w)) begin
                    n_used = r_used - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_req_ready = 1'b0;
        o_done      = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            ST_DECIDE: begin
                if (do_insert && has_room) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_used[IDX_W-1:0];
                    o_mem_wdata = r_value;
                end
            end
            ST_SH_RD: begin
                o_mem_raddr = idx_inc;
            end
            ST_SH_WR: begin
                o_mem_we = 1'b1;
            end
            ST_DONE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Result fields; the count shows its low bits only
    assign count_ext = {{COUNT_OUT_BITS{1'b0}}, r_used};
    assign o_result.was_present  = r_found;
    assign o_result.dropped_full = r_dropped;
    assign o_result.member_count = count_ext[COUNT_OUT_BITS-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_kind    <= n_kind;
        r_value   <= n_value;
        r_found   <= n_found;
        r_dropped <= n_dropped;
    end

    // Fill count never passes the capacity
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_used) <= CMP_W'(CAPACITY))
        else $error("fill count above capacity");

    // A drop only happens on an insert into a full set
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_dropped) |->
            (r_kind == KIND_INSERT && CMP_W'(r_used) == CMP_W'(CAPACITY) && !r_found))
        else $error("drop without a full set");

    // Compaction runs only for a remove that found its value
    a_shift_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SH_RD || r_state == ST_SH_WR) |-> (r_kind == KIND_REMOVE && r_found))
        else $error("shift outside a remove");

    // Count moves by at most one per request and only before the result
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |=> $stable(r_used))
        else $error("count changed outside the work phase");

    // Shifting stays within the filled entries
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SH_WR) |-> (idx_p1 < used_w))
        else $error("shift past the last entry");

endmodule

// ===== hdl/array_set_table.sv =====
// Sequence: each entry searched takes a read state, then a compare state; a decide state follows,
// then a read and a write state for each entry moved down on a remove, and a done state hands
// over the result.
// Throughput: one request at a time, the next taken once the result is handed over; the entry
// memory's single read port and one comparator set the pace. A stalled output holds the handover.
// Reset (synchronous, active low) empties the set; entry contents are not cleared.
module array_set_table #(
    parameter int CAPACITY   = ast_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = ast_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ast_pkg::ITEM_BITS-1:0]     s_axis_tdata,  // [31:0] item_value
    input  logic [ast_pkg::KIND_BITS-1:0]     s_axis_tuser,  // [1:0] kind
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ast_pkg::RES_DATA_BITS-1:0] m_axis_tdata   // [0] was_present,
                                                             // [1] dropped_full,
                                                             // [8:2] member_count
);
    import ast_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = RES_DATA_BITS - COUNT_OUT_BITS - 2;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic                  done;
    logic                  out_free;
    t_result               result;

    logic                  r_m_valid;
    t_result               r_m_result;

    ast_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_kind       (s_axis_tuser),
        .i_item_value (s_axis_tdata),
        .o_done       (done),
        .i_take       (out_free),
        .o_result     (result),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    ast_store #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_m_result <= result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_m_result.member_count,
                            r_m_result.dropped_full, r_m_result.was_present};

    // A waiting result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // Only one request in flight: no new request while a result is being built
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second request accepted during work");

    // A result never lands in a full output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && out_free) |=> m_axis_tvalid)
        else $error("result lost");

endmodule

// ===== tb/array_set_table_test.sv =====
`timescale 1ns / 1ps

module array_set_table_test;
    import ast_pkg::*;

    localparam int SET_CAP = CAPACITY_DEF;
    localparam int POOL_SIZE = SET_CAP + 8;
    localparam int RANDOM_REQS = 1150;
    // the spare kind code behaves like a membership check
    localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ITEM_BITS-1:0] value;
    } t_set_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [ITEM_BITS-1:0] s_axis_tdata = '0;   // [31:0] item_value
    logic [KIND_BITS-1:0] s_axis_tuser = '0;   // [1:0] kind
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [RES_DATA_BITS-1:0] m_axis_tdata;    // [0] was_present, [1] dropped_full,
                                               // [8:2] member_count

    t_set_req request_queue[$];
    t_result status_due[$];
    logic [ITEM_BITS-1:0] set_members[$];
    logic [ITEM_BITS-1:0] value_pool[POOL_SIZE];
    int mismatches = 0;
    int results_seen = 0;
    int req_wait = 0;
    int res_wait = 0;
    bit req_calm = 1'b0;
    bit res_calm = 1'b0;

    array_set_table uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // set behavior: update the member list, return the status of the request
    function automatic t_result apply_set_op(input logic [KIND_BITS-1:0] kind,
                                             input logic [ITEM_BITS-1:0] value);
        t_result res;
        int slot;
        slot = -1;
        foreach (set_members[i])
            if (slot < 0 && set_members[i] == value) slot = i;
        res.was_present = (slot >= 0);
        res.dropped_full = 1'b0;
        if (kind == KIND_INSERT && slot < 0) begin
            if (set_members.size() < SET_CAP)
                set_members.push_back(value);
            else
                res.dropped_full = 1'b1;
        end else if (kind == KIND_REMOVE && slot >= 0) begin
            set_members.delete(slot);
        end
        res.member_count = COUNT_OUT_BITS'(set_members.size());
        return res;
    endfunction

    // per-request or per-result wait, with calm stretches where nothing idles
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 40) == 0) calm = !calm;
        if (calm) return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("tb: result %0d %s mismatch: expected %0d, got %0d",
                 results_seen, what, want, got);
        mismatches++;
    endtask

    task automatic queue_req(input logic [KIND_BITS-1:0] kind,
                             input logic [ITEM_BITS-1:0] value);
        t_set_req req;
        req.kind = kind;
        req.value = value;
        request_queue.push_back(req);
    endtask

    task automatic build_requests();
        int queued;
        int mode;
        int len;
        int offs;
        int idx;
        int roll;
        bit rev;
        logic [KIND_BITS-1:0] kind;
        logic [ITEM_BITS-1:0] value;

        // directed: extremes, every kind, present/absent corner cases
        queue_req(KIND_INSERT, 32'h0000_0000);
        queue_req(KIND_INSERT, 32'hFFFF_FFFF);
        queue_req(KIND_INSERT, 32'h0000_0000);     // already present
        queue_req(KIND_CHECK,  32'hFFFF_FFFF);
        queue_req(KIND_CHECK,  32'h0000_0005);
        queue_req(KIND_SPARE,  32'h0000_0000);
        queue_req(KIND_SPARE,  32'h1234_5678);
        queue_req(KIND_REMOVE, 32'h0001_2345);     // absent
        queue_req(KIND_REMOVE, 32'h0000_0000);     // first entry, shift down
        queue_req(KIND_CHECK,  32'h0000_0000);
        queue_req(KIND_INSERT, 32'hA5A5_A5A5);
        queue_req(KIND_INSERT, 32'h5A5A_5A5A);
        queue_req(KIND_REMOVE, 32'hA5A5_A5A5);     // middle entry
        queue_req(KIND_REMOVE, 32'h5A5A_5A5A);     // last entry
        queue_req(KIND_REMOVE, 32'hFFFF_FFFF);     // now empty
        queue_req(KIND_REMOVE, 32'hFFFF_FFFF);     // remove on empty
        queue_req(KIND_CHECK,  32'hFFFF_FFFF);
        queue_req(KIND_INSERT, 32'h8000_0001);
        queue_req(KIND_REMOVE, 32'h8000_0001);

        // value pool slightly larger than the capacity so sweeps overflow
        foreach (value_pool[i]) value_pool[i] = $urandom();
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;

        queued = 0;
        while (queued < RANDOM_REQS) begin
            mode = $urandom_range(0, 3);
            case (mode)
                0, 3: begin
                    // sweep the pool: fill past capacity, or drain every value
                    offs = $urandom_range(0, POOL_SIZE - 1);
                    rev = ($urandom_range(0, 1) == 1);
                    for (int k = 0; k < POOL_SIZE; k++) begin
                        idx = rev ? (offs + POOL_SIZE - k) % POOL_SIZE : (offs + k) % POOL_SIZE;
                        kind = (mode == 0) ? KIND_INSERT : KIND_REMOVE;
                        if ($urandom_range(0, 7) == 0) kind = KIND_CHECK;
                        queue_req(kind, value_pool[idx]);
                        queued++;
                    end
                end
                default: begin
                    // random mix, drain-leaning or balanced, with some noise
                    len = $urandom_range(40, 120);
                    for (int k = 0; k < len; k++) begin
                        roll = $urandom_range(0, 9);
                        if ($urandom_range(0, 9) == 0) begin
                            kind = KIND_BITS'($urandom_range(0, 3));
                            value = $urandom();
                        end else begin
                            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
                            if (roll < ((mode == 1) ? 2 : 4))
                                kind = KIND_INSERT;
                            else if (roll < 7)
                                kind = KIND_REMOVE;
                            else if (roll < 9)
                                kind = KIND_CHECK;
                            else
                                kind = KIND_SPARE;
                        end
                        queue_req(kind, value);
                        queued++;
                    end
                end
            endcase
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        t_set_req req;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                status_due.push_back(apply_set_op(s_axis_tuser, s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_wait > 0) begin
                    s_axis_tvalid <= 1'b0;
                    req_wait <= req_wait - 1;
                end else if (request_queue.size() > 0) begin
                    req = request_queue.pop_front();
                    s_axis_tuser <= req.kind;
                    s_axis_tdata <= req.value;
                    s_axis_tvalid <= 1'b1;
                    req_wait <= draw_wait(req_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin : check_results
        t_result want;
        int w;
        if (i_rst_n) begin
            w = res_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected", 0, 1);
                end else begin
                    want = status_due.pop_front();
                    if (m_axis_tdata[0] !== want.was_present)
                        report_mismatch("was_present", int'(want.was_present),
                                        int'(m_axis_tdata[0]));
                    if (m_axis_tdata[1] !== want.dropped_full)
                        report_mismatch("dropped_full", int'(want.dropped_full),
                                        int'(m_axis_tdata[1]));
                    if (m_axis_tdata[8:2] !== want.member_count)
                        report_mismatch("member_count", int'(want.member_count),
                                        int'(m_axis_tdata[8:2]));
                end
                results_seen++;
                w = draw_wait(res_calm);
            end
            if (w > 0) begin
                m_axis_tready <= 1'b0;
                res_wait <= w - 1;
            end else begin
                m_axis_tready <= 1'b1;
                res_wait <= 0;
            end
        end
    end

    // reset, run, drain
    initial begin
        build_requests();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (request_queue.size() > 0 || s_axis_tvalid || status_due.size() > 0)
            @(posedge i_clk);
        repeat (2 * SET_CAP + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #1_500_000;
        $display("tb: failure");
        $finish;
    end

endmodule
